>>> rtl/bdq_pkg.sv
// shared types and constants for the bounded deque with search
package bdq_pkg;

    localparam int DATA_W   = 32;
    localparam int ACTION_W = 3;
    localparam int COUNT_W  = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_SEARCH     = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] search_key;
    } req_item_t;

    typedef struct packed {
        logic               found;
        logic               rejected;
        logic [COUNT_W-1:0] stored_count;
    } rsp_item_t;

endpackage

>>> rtl/bdq_mem.sv
// ring storage: one write port, one read port with registered read data
module bdq_mem
    import bdq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic signed [DATA_W-1:0]     wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic signed [DATA_W-1:0]     rd_data
);

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/bdq_ctrl.sv
// sequencer: front index, count, search walk and result register
module bdq_ctrl
    import bdq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  req_item_t                    req,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output rsp_item_t                    rsp,
    output logic                         wr_en,
    output logic [$clog2(DEPTH)-1:0]     wr_addr,
    output logic signed [DATA_W-1:0]     wr_data,
    output logic                         rd_en,
    output logic [$clog2(DEPTH)-1:0]     rd_addr,
    input  logic signed [DATA_W-1:0]     rd_data
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    state_t                   state_reg, state_next;
    logic [IW-1:0]            front_reg, front_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [IW-1:0]            ptr_reg, ptr_next;
    logic [CW-1:0]            left_reg, left_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic                     found_reg, found_next;
    logic                     rejected_reg, rejected_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    rsp_item_t                rsp_reg, rsp_next;

    logic          accept;
    logic          full;
    logic          empty;
    logic          is_push;
    logic          is_search;
    logic          hit;
    logic          last;
    logic          rsp_free;
    logic          load_rsp;
    logic [IW-1:0] front_dec;
    logic [IW-1:0] front_inc;
    logic [IW-1:0] ptr_inc;
    logic [SW-1:0] back_sum;
    logic [IW-1:0] back_pos;

    assign accept    = (state_reg == ST_IDLE) && req_valid;
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign is_push   = (req.action == ACT_PUSH_FRONT) || (req.action == ACT_PUSH_BACK);
    assign is_search = (req.action == ACT_SEARCH);
    assign hit       = (rd_data == key_reg);
    assign last      = (left_reg == CW'(1));
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign load_rsp  = (state_reg == ST_RESULT) && rsp_free;

    // ring index arithmetic, wrapping at DEPTH
    assign front_dec = (front_reg == '0) ? IW'(DEPTH - 1) : front_reg - IW'(1);
    assign front_inc = (front_reg == IW'(DEPTH - 1)) ? '0 : front_reg + IW'(1);
    assign ptr_inc   = (ptr_reg == IW'(DEPTH - 1)) ? '0 : ptr_reg + IW'(1);
    assign back_sum  = SW'(front_reg) + SW'(count_reg);
    assign back_pos  = (back_sum >= SW'(DEPTH)) ? IW'(back_sum - SW'(DEPTH)) : IW'(back_sum);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = (is_search && !empty) ? ST_SEARCH : ST_RESULT;
                end
            end
            ST_SEARCH:
            begin
                if (hit || last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs towards the request side and the memory
    always_comb
    begin
        req_stall = 1'b1;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = ptr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                wr_en     = accept && is_push && !full;
                rd_en     = accept && is_search && !empty;
                rd_addr   = front_reg;
            end
            ST_SEARCH:
            begin
                rd_en = !hit && !last;
            end
            ST_RESULT:
            begin
                req_stall = 1'b1;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    assign wr_addr = (req.action == ACT_PUSH_FRONT) ? front_dec : back_pos;
    assign wr_data = req.value;

    // datapath next values
    always_comb
    begin
        front_next    = front_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        left_next     = left_reg;
        key_next      = key_reg;
        found_next    = found_reg;
        rejected_next = rejected_reg;
        if (accept)
        begin
            key_next      = req.search_key;
            found_next    = 1'b0;
            rejected_next = 1'b0;
            ptr_next      = front_inc;
            left_next     = count_reg;
            unique case (req.action)
                ACT_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        rejected_next = 1'b1;
                    end
                    else
                    begin
                        front_next = front_dec;
                        count_next = count_reg + CW'(1);
                    end
                end
                ACT_PUSH_BACK:
                begin
                    if (full)
                    begin
                        rejected_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
                ACT_POP_FRONT:
                begin
                    if (!empty)
                    begin
                        front_next = front_inc;
                        count_next = count_reg - CW'(1);
                    end
                end
                ACT_POP_BACK:
                begin
                    if (!empty)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
        else if (state_reg == ST_SEARCH)
        begin
            if (hit)
            begin
                found_next = 1'b1;
            end
            else if (!last)
            begin
                ptr_next  = ptr_inc;
                left_next = left_reg - CW'(1);
            end
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (load_rsp)
        begin
            rsp_valid_next        = 1'b1;
            rsp_next.found        = found_reg;
            rsp_next.rejected     = rejected_reg;
            rsp_next.stored_count = COUNT_W'(count_reg);
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        left_reg     <= left_next;
        key_reg      <= key_next;
        found_reg    <= found_next;
        rejected_reg <= rejected_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> rtl/bounded_deque_with_search_core.sv
// top level of the bounded deque with search
//
// request channel req_valid / req_stall / req carries one action per
// transaction: push front, push back, pop front, pop back or search.
// every request gives exactly one transaction on rsp_valid / rsp_stall /
// rsp with found, rejected and the count held after the request.
// a push into a full ring is refused with rejected set; a pop from an
// empty ring leaves everything unchanged.
// values sit in a ring memory of DEPTH entries with a registered read
// port; a search reads one stored entry per cycle from the front and
// stops at the first match.
// push and pop pass from acceptance through ST_RESULT into the output
// register. a search walks ST_SEARCH first and compares n entries, n
// at most the count and so at most DEPTH; the single read port makes it serial.
// one request is in flight at a time; req_stall is high while it is.
// a finished result waits in the output register while rsp_stall is high
// and the next request may already be accepted.
// reset empties the deque at once; no clearing pass is needed.
module bounded_deque_with_search_core
    import bdq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    localparam int IW = $clog2(DEPTH);

    logic                     wr_en;
    logic [IW-1:0]            wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic                     rd_en;
    logic [IW-1:0]            rd_addr;
    logic signed [DATA_W-1:0] rd_data;

    bdq_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    bdq_mem #(
        .DEPTH(DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

>>> tb/sv/bdq_response_checker.sv
// checker for the bounded deque: predicts each response and compares it with the block's output
module bdq_response_checker
    import bdq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_stall,
    input  req_item_t req,
    input  logic      rsp_valid,
    input  logic      rsp_stall,
    input  rsp_item_t rsp,
    output int        failures,
    output int        pending
);

    localparam int IDX_W        = $clog2(DEPTH);
    localparam int REPORT_LIMIT = 10;

    logic signed [DATA_W-1:0] ring [DEPTH];
    logic [IDX_W-1:0]         head;
    logic [COUNT_W-1:0]       held;
    rsp_item_t                expected_rsp_q [$];
    rsp_item_t                want;

    function automatic logic [IDX_W-1:0] slot(input int offset);
        int unsigned pos;
        pos = (int'(head) + offset) % DEPTH;
        return pos[IDX_W-1:0];
    endfunction

    function automatic rsp_item_t apply_request(input req_item_t r);
        rsp_item_t res;
        res = '0;
        case (r.action)
            ACT_PUSH_FRONT:
                if (held >= DEPTH)
                    res.rejected = 1'b1;
                else
                begin
                    head       = slot(DEPTH - 1);
                    ring[head] = r.value;
                    held       = held + 1'b1;
                end
            ACT_PUSH_BACK:
                if (held >= DEPTH)
                    res.rejected = 1'b1;
                else
                begin
                    ring[slot(int'(held))] = r.value;
                    held                   = held + 1'b1;
                end
            ACT_POP_FRONT:
                if (held != 0)
                begin
                    head = slot(1);
                    held = held - 1'b1;
                end
            ACT_POP_BACK:
                if (held != 0)
                    held = held - 1'b1;
            ACT_SEARCH:
                for (int i = 0; i < held; i++)
                    if (ring[slot(i)] == r.search_key)
                        res.found = 1'b1;
            default:
                ;
        endcase
        res.stored_count = held;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head     = '0;
            held     = '0;
            expected_rsp_q.delete();
            failures = 0;
            pending  = 0;
        end
        else
        begin
            // response first: it always belongs to an earlier request
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    if (failures < REPORT_LIMIT)
                        $display("unexpected response transaction: %s=%0b %s=%0b count=%0d",
                                 "found", rsp.found, "rejected", rsp.rejected,
                                 rsp.stored_count);
                    failures++;
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp.found !== want.found || rsp.rejected !== want.rejected ||
                        rsp.stored_count !== want.stored_count)
                    begin
                        if (failures < REPORT_LIMIT)
                            $display({"response mismatch: expected found=%0b rejected=%0b ",
                                      "count=%0d, got found=%0b rejected=%0b count=%0d"},
                                     want.found, want.rejected, want.stored_count,
                                     rsp.found, rsp.rejected, rsp.stored_count);
                        failures++;
                    end
                end
            end
            if (req_valid && !req_stall)
                expected_rsp_q.push_back(apply_request(req));
            pending = expected_rsp_q.size();
        end
    end

endmodule

>>> tb/sv/testbench.sv
// top of the bounded deque testbench: clock, reset, request stimulus and the verdict
module testbench;
    import bdq_pkg::*;

    localparam int DEPTH          = 16;
    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = DEPTH + 4;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int POOL_SIZE      = 8;
    localparam int TIDE_LEN       = 24;

    localparam logic [ACTION_W-1:0] ACT_FIRST_UNUSED = ACTION_W'(ACT_SEARCH + 1);
    localparam logic [ACTION_W-1:0] ACT_LAST_UNUSED  = {ACTION_W{1'b1}};
    localparam logic signed [DATA_W-1:0] VALUE_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] VALUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_item_t req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_item_t rsp;
    int        failures;
    int        pending;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    logic signed [DATA_W-1:0] value_pool [POOL_SIZE];

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
        rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    bounded_deque_with_search_core #(
        .DEPTH(DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    bdq_response_checker #(
        .DEPTH(DEPTH)
    ) deque_monitor (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp),
        .failures (failures),
        .pending  (pending)
    );

    function automatic req_item_t request_of(input logic [ACTION_W-1:0] action,
                                             input logic signed [DATA_W-1:0] value,
                                             input logic signed [DATA_W-1:0] key);
        req_item_t item;
        item.action     = action;
        item.value      = value;
        item.search_key = key;
        return item;
    endfunction

    function automatic req_item_t random_request(input int push_pct);
        req_item_t item;
        int        roll;
        item.value      = $urandom_range(0, 1) ? value_pool[$urandom_range(0, POOL_SIZE - 1)]
                                               : $urandom;
        item.search_key = ($urandom_range(0, 99) < 60)
                          ? value_pool[$urandom_range(0, POOL_SIZE - 1)]
                          : $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            item.action = ACTION_W'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_UNUSED));
        else if ($urandom_range(0, 99) < push_pct)
            item.action = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
        else
        begin
            roll = $urandom_range(0, 9);
            item.action = (roll < 4) ? ACT_SEARCH : (roll < 7) ? ACT_POP_FRONT : ACT_POP_BACK;
        end
        return item;
    endfunction

    task automatic send_request(input req_item_t item);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // hold off until every outstanding response has been taken
    task automatic drain_responses();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic run_phase(input int items, input int send_pct, input int recv_pct);
        int push_pct;
        push_pct      = 50;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        foreach (value_pool[k])
            value_pool[k] = $urandom;
        value_pool[0] = VALUE_MIN;
        value_pool[1] = VALUE_MAX;
        value_pool[2] = '0;
        for (int n = 0; n < items; n++)
        begin
            // tides of mostly pushes, mostly pops or a mix so the ring fills and empties
            if (n % TIDE_LEN == 0)
                case ($urandom_range(0, 2))
                    0:       push_pct = 85;
                    1:       push_pct = 15;
                    default: push_pct = 55;
                endcase
            send_request(random_request(push_pct));
        end
        drain_responses();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty ring, unused codes, fill with extremes, refused pushes, searches, pops
        send_request(request_of(ACT_POP_FRONT, VALUE_MAX, VALUE_MIN));
        send_request(request_of(ACT_POP_BACK, VALUE_MIN, VALUE_MAX));
        send_request(request_of(ACT_SEARCH, VALUE_MAX, '0));
        for (int a = int'(ACT_FIRST_UNUSED); a <= int'(ACT_LAST_UNUSED); a++)
            send_request(request_of(a[ACTION_W-1:0], $urandom, $urandom));
        for (int k = 0; k < DEPTH; k++)
            send_request(request_of(k[0] ? ACT_PUSH_BACK : ACT_PUSH_FRONT,
                                    (k == 0) ? VALUE_MIN : (k == 1) ? VALUE_MAX : $urandom,
                                    $urandom));
        send_request(request_of(ACT_PUSH_FRONT, VALUE_MAX, '0));
        send_request(request_of(ACT_PUSH_BACK, VALUE_MIN, '0));
        send_request(request_of(ACT_SEARCH, '0, VALUE_MIN));
        send_request(request_of(ACT_SEARCH, '0, VALUE_MAX));
        send_request(request_of(ACT_POP_FRONT, '0, '0));
        send_request(request_of(ACT_POP_BACK, '0, '0));
        drain_responses();

        run_phase(285, 21, 57);
        run_phase(285, 57, 21);
        run_phase(280, 0, 0);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
